/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL.
// Define NO_ASSERTIONS to compile every use to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Concurrent check, disabled while the active-low reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold at a clock edge.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/lcal_pkg.sv */
`timescale 1ns / 1ps

package lcal_pkg;

	localparam int NODE_COUNT  = 1024;
	localparam int LIFT_LEVELS = 11;
	localparam int NODE_W      = 10;
	localparam int DEPTH_W     = 11;
	localparam int LVL_W       = $clog2(LIFT_LEVELS);
	localparam int ROW_W       = DEPTH_W + LIFT_LEVELS * NODE_W;

	typedef logic [NODE_W-1:0]  node_t;
	typedef logic [DEPTH_W-1:0] depth_t;
	typedef logic [LVL_W-1:0]   lvl_t;

	// One memory row: a node's depth and all of its 2^i ancestors.
	typedef struct packed {
		depth_t                     depth;
		logic [LIFT_LEVELS-1:0][NODE_W-1:0] anc;
	} row_t;

	localparam logic OP_ATTACH = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	localparam lvl_t LVL_TOP = lvl_t'(LIFT_LEVELS - 1);

endpackage

/* rtl/lowest_common_ancestor_lifting.sv */
`timescale 1ns / 1ps
// Channel   Valid      Stall      Payload
// input     in_valid   in_stall   opcode, node_a, node_b
// output    out_valid  out_stall  ancestor
//
// After reset the block sweeps both copies of the node table, one row per cycle,
// writing zeros to all 1024 rows; in_stall stays high during the sweep.
// An attach reads the parent row, makes ten dependent ancestor reads through memory
// port A and writes one row. An ignored attach leaves the block idle.
// A query makes eleven dependent reads to equalize depths; unless the lifted node
// then equals the other node, eleven paired reads follow to climb together.
// One item is in work at a time. A finished result sits in the output register, so a
// stalled output does not hold off the next transaction unless a second result is ready.

module lowest_common_ancestor_lifting (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  opcode,
	input  logic [9:0]            node_a,
	input  logic [9:0]            node_b,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [9:0]            ancestor
);

`include "assert_macros.svh"

	// Each node owns one row holding its depth and every 2^i ancestor. Two identical
	// copies of the table give two read ports; every write goes to both copies.

	typedef enum logic [10:0] {
		ST_CLEAR     = 11'b000_0000_0001,
		ST_IDLE      = 11'b000_0000_0010,
		ST_ATT_LVL   = 11'b000_0000_0100,
		ST_ATT_WR    = 11'b000_0000_1000,
		ST_LOAD      = 11'b000_0001_0000,
		ST_LIFT      = 11'b000_0010_0000,
		ST_LIFT_END  = 11'b000_0100_0000,
		ST_CLIMB     = 11'b000_1000_0000,
		ST_CLIMB_END = 11'b001_0000_0000,
		ST_DONE      = 11'b010_0000_0000,
		ST_SPARE     = 11'b100_0000_0000
	} state_t;

	state_t              state_q;
	lcal_pkg::lvl_t      lvl_q;
	logic                pend_q;
	lcal_pkg::node_t     clr_q;
	lcal_pkg::node_t     child_q;
	lcal_pkg::node_t     node_u_q;
	lcal_pkg::node_t     node_v_q;
	lcal_pkg::node_t     rd_addr_q;
	lcal_pkg::node_t     res_q;
	lcal_pkg::row_t      new_row_q;
	lcal_pkg::row_t      row_u_q;
	lcal_pkg::row_t      row_v_q;
	logic                out_valid_q;
	lcal_pkg::node_t     ancestor_q;

	logic                mem_we;
	lcal_pkg::node_t     mem_waddr;
	lcal_pkg::row_t      mem_wdata;
	lcal_pkg::node_t     raddr_a;
	lcal_pkg::node_t     raddr_b;
	logic [lcal_pkg::ROW_W-1:0] rdata_a_raw;
	logic [lcal_pkg::ROW_W-1:0] rdata_b_raw;
	lcal_pkg::row_t      rd_a;
	lcal_pkg::row_t      rd_b;

	lcal_pkg::row_t      fwd_a;
	logic                take;
	lcal_pkg::row_t      cur_u_lift;
	lcal_pkg::node_t     cur_node_lift;
	lcal_pkg::row_t      cur_u_climb;
	lcal_pkg::row_t      cur_v_climb;
	logic                differ;
	logic                in_accept;
	logic                out_load;
	logic                swap;

	lcal_ram #(
		.WIDTH(lcal_pkg::ROW_W),
		.DEPTH(lcal_pkg::NODE_COUNT)
	) u_ram_a (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(raddr_a),
		.rdata(rdata_a_raw)
	);

	lcal_ram #(
		.WIDTH(lcal_pkg::ROW_W),
		.DEPTH(lcal_pkg::NODE_COUNT)
	) u_ram_b (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(raddr_b),
		.rdata(rdata_b_raw)
	);

	assign rd_a = lcal_pkg::row_t'(rdata_a_raw);
	assign rd_b = lcal_pkg::row_t'(rdata_b_raw);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign ancestor  = ancestor_q;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// While an attach is building the child row, a read of the child itself must see
	// the levels already computed, not the stale row in memory.
	assign fwd_a = (rd_addr_q == child_q) ? new_row_q : rd_a;

	// Depth lifting: the candidate read last cycle replaces u when it is not shallower
	// than v.
	assign take          = pend_q && (rd_a.depth >= row_v_q.depth);
	assign cur_u_lift    = take ? rd_a : row_u_q;
	assign cur_node_lift = take ? rd_addr_q : node_u_q;

	// Joint climb: both rows move when their ancestors differed at the previous level.
	assign cur_u_climb = pend_q ? rd_a : row_u_q;
	assign cur_v_climb = pend_q ? rd_b : row_v_q;
	assign differ      = cur_u_climb.anc[lvl_q] != cur_v_climb.anc[lvl_q];

	assign swap = rd_a.depth < rd_b.depth;

	always_comb begin
		raddr_a   = '0;
		raddr_b   = '0;
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				raddr_a = (opcode == lcal_pkg::OP_ATTACH) ? node_b : node_a;
				raddr_b = node_b;
			end
			ST_ATT_LVL: begin
				raddr_a = fwd_a.anc[lvl_q - lcal_pkg::lvl_t'(1)];
			end
			ST_ATT_WR: begin
				mem_we    = 1'b1;
				mem_waddr = child_q;
				mem_wdata = new_row_q;
			end
			ST_LIFT: begin
				raddr_a = cur_u_lift.anc[lvl_q];
			end
			ST_CLIMB: begin
				raddr_a = cur_u_climb.anc[lvl_q];
				raddr_b = cur_v_climb.anc[lvl_q];
			end
			default: begin
				raddr_a = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			lvl_q       <= '0;
			pend_q      <= 1'b0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + lcal_pkg::node_t'(1);
					if (clr_q == lcal_pkg::node_t'(lcal_pkg::NODE_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_accept) begin
						if (opcode == lcal_pkg::OP_QUERY) begin
							state_q <= ST_LOAD;
						end else if (node_a != '0 && node_a != node_b) begin
							lvl_q   <= lcal_pkg::lvl_t'(1);
							state_q <= ST_ATT_LVL;
						end
					end
				end
				ST_ATT_LVL: begin
					if (lvl_q == lcal_pkg::LVL_TOP) begin
						state_q <= ST_ATT_WR;
					end else begin
						lvl_q <= lvl_q + lcal_pkg::lvl_t'(1);
					end
				end
				ST_ATT_WR: begin
					state_q <= ST_IDLE;
				end
				ST_LOAD: begin
					lvl_q   <= lcal_pkg::LVL_TOP;
					pend_q  <= 1'b0;
					state_q <= ST_LIFT;
				end
				ST_LIFT: begin
					pend_q <= 1'b1;
					if (lvl_q == '0) begin
						state_q <= ST_LIFT_END;
					end else begin
						lvl_q <= lvl_q - lcal_pkg::lvl_t'(1);
					end
				end
				ST_LIFT_END: begin
					pend_q <= 1'b0;
					lvl_q  <= lcal_pkg::LVL_TOP;
					if (cur_node_lift == node_v_q) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_CLIMB;
					end
				end
				ST_CLIMB: begin
					pend_q <= differ;
					if (lvl_q == '0) begin
						state_q <= ST_CLIMB_END;
					end else begin
						lvl_q <= lvl_q - lcal_pkg::lvl_t'(1);
					end
				end
				ST_CLIMB_END: begin
					pend_q  <= 1'b0;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; none of them needs a reset value.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				child_q   <= node_a;
				node_u_q  <= node_a;
				node_v_q  <= node_b;
				rd_addr_q <= node_b;
			end
			ST_ATT_LVL: begin
				if (lvl_q == lcal_pkg::lvl_t'(1)) begin
					// The parent row arrives now: depth and the first two levels.
					new_row_q.depth  <= (fwd_a.depth == '1) ? fwd_a.depth
						: fwd_a.depth + lcal_pkg::depth_t'(1);
					new_row_q.anc[0] <= rd_addr_q;
				end
				new_row_q.anc[lvl_q] <= fwd_a.anc[lvl_q - lcal_pkg::lvl_t'(1)];
				rd_addr_q            <= raddr_a;
			end
			ST_LOAD: begin
				row_u_q  <= swap ? rd_b : rd_a;
				row_v_q  <= swap ? rd_a : rd_b;
				node_u_q <= swap ? node_v_q : node_u_q;
				node_v_q <= swap ? node_u_q : node_v_q;
			end
			ST_LIFT: begin
				row_u_q   <= cur_u_lift;
				node_u_q  <= cur_node_lift;
				rd_addr_q <= raddr_a;
			end
			ST_LIFT_END: begin
				row_u_q  <= cur_u_lift;
				node_u_q <= cur_node_lift;
				res_q    <= cur_node_lift;
			end
			ST_CLIMB: begin
				row_u_q <= cur_u_climb;
				row_v_q <= cur_v_climb;
			end
			ST_CLIMB_END: begin
				res_q <= cur_u_climb.anc[0];
			end
			default: begin
				res_q <= res_q;
			end
		endcase
		if (out_load) begin
			ancestor_q <= res_q;
		end
	end

	// The table is written only by the clearing sweep and by the end of an attach.
	`ASSERT_CLK(a_write_src, clk, arst_n,
		mem_we |-> (state_q == ST_CLEAR || state_q == ST_ATT_WR),
		"table written outside the clearing sweep or an attach")

	// Depth lifting never takes u above the depth of v.
	`ASSERT_CLK(a_lift_depth, clk, arst_n,
		(state_q == ST_LIFT || state_q == ST_LIFT_END) |-> row_u_q.depth >= row_v_q.depth,
		"lifted node became shallower than the other node")

	// A result appears only when a query has finished.
	`ASSERT_CLK(a_out_from_done, clk, arst_n,
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE,
		"result presented without a finished query")

	// The level counter stays within the ancestor levels while walking.
	`ASSERT_NEVER(a_lvl_range, clk, arst_n,
		(state_q == ST_LIFT || state_q == ST_CLIMB || state_q == ST_ATT_LVL)
		&& lvl_q > lcal_pkg::LVL_TOP,
		"lift level out of range")

endmodule

/* rtl/lcal_ram.sv */
`timescale 1ns / 1ps

module lcal_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* tb/lowest_common_ancestor_lifting_tb.sv */
`timescale 1ns / 1ps

module lowest_common_ancestor_lifting_tb;

	// The deepest a node can get; deeper attaches saturate here.
	localparam lcal_pkg::depth_t DEPTH_CAP = '1;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              opcode;
	lcal_pkg::node_t   node_a;
	lcal_pkg::node_t   node_b;
	logic              out_valid;
	logic              out_stall;
	lcal_pkg::node_t   ancestor;

	lowest_common_ancestor_lifting u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.node_a    (node_a),
		.node_b    (node_b),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ancestor  (ancestor)
	);

	// Shadow copy of the lifting table and the depth table. These are updated
	// at the moment the block accepts an attach transaction, so every query sees
	// exactly the tree the block had when it took that query.
	lcal_pkg::node_t  lift_tab  [lcal_pkg::NODE_COUNT][lcal_pkg::LIFT_LEVELS];
	lcal_pkg::depth_t level_tab [lcal_pkg::NODE_COUNT];

	// Ancestors still owed by the block, oldest first.
	lcal_pkg::node_t  ancestor_q [$];

	int unsigned err_count;
	int unsigned results_seen;

	// Sender burst bookkeeping.
	int unsigned burst_left;

	// Bookkeeping for the random tree builder.
	bit               placed_mark [lcal_pkg::NODE_COUNT];
	lcal_pkg::node_t  placed_list [$];

	// One row of the directed stimulus. Rows whose answer is obvious carry it
	// typed in; the rest fall back on the shadow model.
	typedef struct {
		logic            op;
		lcal_pkg::node_t a;
		lcal_pkg::node_t b;
		bit              typed;
		lcal_pkg::node_t want;
	} vec_t;

	vec_t plan [25] = '{
		// Fresh after reset every node is unattached, so every answer is zero.
		'{lcal_pkg::OP_QUERY,  10'd0,    10'd0,    1'b1, 10'd0},
		'{lcal_pkg::OP_QUERY,  10'd1023, 10'd1023, 1'b1, 10'd0},
		'{lcal_pkg::OP_QUERY,  10'd0,    10'd1023, 1'b1, 10'd0},
		// Attaching the sentinel and a self loop must both be dropped.
		'{lcal_pkg::OP_ATTACH, 10'd0,    10'd5,    1'b0, 10'd0},
		'{lcal_pkg::OP_ATTACH, 10'd7,    10'd7,    1'b0, 10'd0},
		// A small tree: 1 is a root, 2 and 3 under it, 4 under 2, 1023 under 4, 512 under 3.
		'{lcal_pkg::OP_ATTACH, 10'd1,    10'd0,    1'b0, 10'd0},
		'{lcal_pkg::OP_ATTACH, 10'd2,    10'd1,    1'b0, 10'd0},
		'{lcal_pkg::OP_ATTACH, 10'd3,    10'd1,    1'b0, 10'd0},
		'{lcal_pkg::OP_ATTACH, 10'd4,    10'd2,    1'b0, 10'd0},
		'{lcal_pkg::OP_ATTACH, 10'd1023, 10'd4,    1'b0, 10'd0},
		'{lcal_pkg::OP_ATTACH, 10'd512,  10'd3,    1'b0, 10'd0},
		'{lcal_pkg::OP_QUERY,  10'd1023, 10'd512,  1'b0, 10'd0},
		'{lcal_pkg::OP_QUERY,  10'd4,    10'd1023, 1'b0, 10'd0},
		'{lcal_pkg::OP_QUERY,  10'd1,    10'd1,    1'b1, 10'd1},
		// Anything against the sentinel climbs all the way to it.
		'{lcal_pkg::OP_QUERY,  10'd1023, 10'd0,    1'b1, 10'd0},
		'{lcal_pkg::OP_QUERY,  10'd7,    10'd7,    1'b1, 10'd0},
		'{lcal_pkg::OP_QUERY,  10'd5,    10'd1,    1'b0, 10'd0},
		'{lcal_pkg::OP_ATTACH, 10'd6,    10'd1023, 1'b0, 10'd0},
		// Moving node 2 under node 3 leaves the old entries of 4 and 1023 alone.
		'{lcal_pkg::OP_ATTACH, 10'd2,    10'd3,    1'b0, 10'd0},
		'{lcal_pkg::OP_QUERY,  10'd4,    10'd512,  1'b0, 10'd0},
		'{lcal_pkg::OP_QUERY,  10'd6,    10'd2,    1'b0, 10'd0},
		'{lcal_pkg::OP_ATTACH, 10'd1023, 10'd1023, 1'b0, 10'd0},
		'{lcal_pkg::OP_QUERY,  10'd1023, 10'd6,    1'b0, 10'd0},
		'{lcal_pkg::OP_ATTACH, 10'd700,  10'd0,    1'b0, 10'd0},
		'{lcal_pkg::OP_QUERY,  10'd700,  10'd6,    1'b0, 10'd0}
	};

	// Place a child under a parent, building each 2^i hop from the hops
	// already stored. Reading the child's own fresh entries is deliberate: when
	// a re-attach closes a loop the block sees the same freshly written values.
	function automatic void graft(lcal_pkg::node_t child, lcal_pkg::node_t parent);
		lcal_pkg::node_t hop;
		if (child == '0 || child == parent) begin
			return;
		end
		level_tab[child] = (level_tab[parent] >= DEPTH_CAP) ? DEPTH_CAP
			: level_tab[parent] + 1'b1;
		lift_tab[child][0] = parent;
		for (int i = 1; i < lcal_pkg::LIFT_LEVELS; i++) begin
			hop = lift_tab[child][i-1];
			lift_tab[child][i] = lift_tab[hop][i-1];
		end
	endfunction

	// Lift the deeper node level by level down to the other one's depth, then
	// climb both while their 2^i ancestors differ.
	function automatic lcal_pkg::node_t meet_of(lcal_pkg::node_t a, lcal_pkg::node_t b);
		lcal_pkg::node_t u;
		lcal_pkg::node_t v;
		lcal_pkg::node_t t;
		u = a;
		v = b;
		if (level_tab[u] < level_tab[v]) begin
			u = b;
			v = a;
		end
		for (int i = lcal_pkg::LIFT_LEVELS - 1; i >= 0; i--) begin
			t = lift_tab[u][i];
			if (level_tab[t] >= level_tab[v]) begin
				u = t;
			end
		end
		if (u == v) begin
			return u;
		end
		for (int i = lcal_pkg::LIFT_LEVELS - 1; i >= 0; i--) begin
			if (lift_tab[u][i] != lift_tab[v][i]) begin
				u = lift_tab[u][i];
				v = lift_tab[v][i];
			end
		end
		return lift_tab[u][0];
	endfunction

	task automatic report_mismatch(input string what, input lcal_pkg::node_t got,
			input lcal_pkg::node_t want);
		$display("[%0t] MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
		err_count++;
	endtask

	// Offer one transaction and hold it until the block takes it. Between
	// bursts the valid may drop for a random gap; inside a burst it stays high, so
	// consecutive transactions never lower and raise valid in the same step.
	task automatic offer(input logic op, input lcal_pkg::node_t a, input lcal_pkg::node_t b,
			input bit typed, input lcal_pkg::node_t want);
		int unsigned gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 3))
				0: gap = 0;
				1: gap = $urandom_range(10, 30);
				default: gap = $urandom_range(1, 6);
			endcase
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		opcode   <= op;
		node_a   <= a;
		node_b   <= b;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		// Taken at this edge: advance the shadow model in the same order.
		if (op == lcal_pkg::OP_ATTACH) begin
			graft(a, b);
		end else if (typed) begin
			ancestor_q.push_back(want);
		end else begin
			ancestor_q.push_back(meet_of(a, b));
		end
	endtask

	function automatic lcal_pkg::node_t any_placed();
		return placed_list[$urandom_range(0, placed_list.size() - 1)];
	endfunction

	// Parent choice for a new node: sometimes a root, often one of the most
	// recent nodes so that branches grow deep, otherwise anywhere in the forest.
	function automatic lcal_pkg::node_t pick_parent();
		int unsigned r;
		int unsigned n;
		r = $urandom_range(0, 99);
		n = placed_list.size();
		if (n == 0 || r < 15) begin
			return '0;
		end
		if (r < 60) begin
			return placed_list[n - 1 - $urandom_range(0, (n < 8) ? n - 1 : 7)];
		end
		return any_placed();
	endfunction

	task automatic attach_fresh();
		lcal_pkg::node_t child;
		lcal_pkg::node_t parent;
		child = lcal_pkg::node_t'($urandom_range(1, lcal_pkg::NODE_COUNT - 1));
		while (placed_mark[child]) begin
			child = lcal_pkg::node_t'($urandom_range(1, lcal_pkg::NODE_COUNT - 1));
		end
		parent = pick_parent();
		offer(lcal_pkg::OP_ATTACH, child, parent, 1'b0, '0);
		placed_mark[child] = 1'b1;
		placed_list.push_back(child);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Stimulus: reset, the directed rows, a random forest, a long chain that is
	// wrapped around on itself, and a last run of random queries.
	initial begin
		lcal_pkg::node_t a;
		lcal_pkg::node_t b;
		lcal_pkg::node_t child;
		lcal_pkg::node_t parent;
		int unsigned     r;

		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		opcode    <= lcal_pkg::OP_ATTACH;
		node_a    <= '0;
		node_b    <= '0;
		err_count  = 0;
		burst_left = 0;
		for (int n = 0; n < lcal_pkg::NODE_COUNT; n++) begin
			level_tab[n]   = '0;
			placed_mark[n] = 1'b0;
			for (int i = 0; i < lcal_pkg::LIFT_LEVELS; i++) begin
				lift_tab[n][i] = '0;
			end
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// The block sweeps its tables after reset with in_stall high; the
		// first offer simply waits that out.
		foreach (plan[k]) begin
			offer(plan[k].op, plan[k].a, plan[k].b, plan[k].typed, plan[k].want);
			if (plan[k].op == lcal_pkg::OP_ATTACH && plan[k].a != plan[k].b
					&& plan[k].a != '0 && !placed_mark[plan[k].a]) begin
				placed_mark[plan[k].a] = 1'b1;
				placed_list.push_back(plan[k].a);
			end
		end

		// Random forest: mostly well-formed growth and queries between placed
		// nodes, with re-attaches and ignored or unattached cases mixed in.
		repeat (300) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				attach_fresh();
			end else if (r < 80) begin
				a = any_placed();
				b = ($urandom_range(0, 9) == 0) ? lcal_pkg::node_t'('0) : any_placed();
				offer(lcal_pkg::OP_QUERY, a, b, 1'b0, '0);
			end else if (r < 88) begin
				offer(lcal_pkg::OP_ATTACH, any_placed(), pick_parent(), 1'b0, '0);
			end else if (r < 94) begin
				a = lcal_pkg::node_t'($urandom_range(0, lcal_pkg::NODE_COUNT - 1));
				b = lcal_pkg::node_t'($urandom_range(0, lcal_pkg::NODE_COUNT - 1));
				offer(lcal_pkg::OP_QUERY, a, b, 1'b0, '0);
			end else if (r < 97) begin
				a = lcal_pkg::node_t'($urandom_range(0, lcal_pkg::NODE_COUNT - 1));
				offer(lcal_pkg::OP_ATTACH, a, a, 1'b0, '0);
			end else begin
				offer(lcal_pkg::OP_ATTACH, '0,
					lcal_pkg::node_t'($urandom_range(0, lcal_pkg::NODE_COUNT - 1)), 1'b0, '0);
			end
		end

		// One chain through every node, then wrapped: node 1 goes under the
		// deepest node, node 2 under node 1, and so on. The wrap closes a loop
		// in the stored ancestors and pushes depths well past a thousand.
		for (int k = 0; k < 1350; k++) begin
			child  = lcal_pkg::node_t'((k % (lcal_pkg::NODE_COUNT - 1)) + 1);
			parent = (k == 0) ? lcal_pkg::node_t'('0)
				: lcal_pkg::node_t'(((k - 1) % (lcal_pkg::NODE_COUNT - 1)) + 1);
			offer(lcal_pkg::OP_ATTACH, child, parent, 1'b0, '0);
			if ($urandom_range(0, 7) == 0) begin
				a = $urandom_range(0, 1) ? child
					: lcal_pkg::node_t'($urandom_range(0, lcal_pkg::NODE_COUNT - 1));
				b = lcal_pkg::node_t'($urandom_range(0, lcal_pkg::NODE_COUNT - 1));
				offer(lcal_pkg::OP_QUERY, a, b, 1'b0, '0);
			end
		end
		repeat (40) begin
			a = lcal_pkg::node_t'($urandom_range(0, lcal_pkg::NODE_COUNT - 1));
			b = lcal_pkg::node_t'($urandom_range(0, lcal_pkg::NODE_COUNT - 1));
			offer(lcal_pkg::OP_QUERY, a, b, 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (ancestor_q.size() != 0) begin
			@(posedge clk);
		end
		// Leave room for any stray result.
		repeat (60) @(posedge clk);
		if (ancestor_q.size() == 0 && err_count == 0) begin
			$display("lowest_common_ancestor_lifting verification clean");
		end else begin
			$display("lowest_common_ancestor_lifting verification failed");
		end
		$finish;
	end

	// Receiver: checks every result transaction and stalls at a random density,
	// drawn from four levels. Once, early on, it holds off for a long
	// stretch so the output register fills and the block stalls its input.
	initial begin
		int unsigned     cyc;
		int unsigned     hold_left;
		int unsigned     stall_pct;
		bit              pressed;
		lcal_pkg::node_t want;

		cyc          = 0;
		hold_left    = 0;
		stall_pct    = 0;
		pressed      = 1'b0;
		results_seen = 0;
		out_stall   <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid === 1'b1 && !out_stall) begin
				results_seen++;
				if (ancestor_q.size() == 0) begin
					report_mismatch("ancestor with no query pending", ancestor, '0);
				end else begin
					want = ancestor_q.pop_front();
					if (ancestor !== want) begin
						report_mismatch("ancestor", ancestor, want);
					end
				end
			end
			if (!pressed && results_seen >= 40) begin
				pressed   = 1'b1;
				hold_left = 400;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (cyc % 128 == 0) begin
					case ($urandom_range(0, 4))
						0, 1: stall_pct = 0;
						2: stall_pct = 25;
						3: stall_pct = 60;
						default: stall_pct = 90;
					endcase
				end
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
			cyc++;
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#4000000;
		$display("lowest_common_ancestor_lifting verification failed");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/lcal_pkg.sv
rtl/lcal_ram.sv
rtl/lowest_common_ancestor_lifting.sv
tb/lowest_common_ancestor_lifting_tb.sv
